@@ src/amt_pkg.sv @@
// Shared types and constants for the box transform block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package amt_pkg;

  localparam int NREGS   = 8;
  localparam int REG_W   = 64;
  localparam int ADDR_W  = 6;
  localparam int ACC_W   = 50;   // row sums stay below 2^48 in magnitude
  localparam int DIV_STAGES = 16; // 32 quotient bits, two per stage
  localparam int DIV_LAT = DIV_STAGES + 2; // prep + bit stages + saturate

  localparam logic [REG_W-1:0] Q_ONE = 64'd65536;

  localparam logic [REG_W-1:0] CFG_RESET [NREGS] = '{
    Q_ONE, 64'd0, Q_ONE << 32, 64'd0, 64'd0, Q_ONE, 64'd0, Q_ONE << 32
  };

  typedef struct packed {
    logic signed [31:0] lo_x;
    logic signed [31:0] lo_y;
    logic signed [31:0] lo_z;
    logic signed [31:0] hi_x;
    logic signed [31:0] hi_y;
    logic signed [31:0] hi_z;
    logic               box_ok;
  } box_t;

  typedef struct packed {
    logic signed [31:0] new_lo_x;
    logic signed [31:0] new_lo_y;
    logic signed [31:0] new_lo_z;
    logic signed [31:0] new_hi_x;
    logic signed [31:0] new_hi_y;
    logic signed [31:0] new_hi_z;
    logic               result_ok;
    logic               divide_fault;
  } result_t;

  // Sideband that travels with each corner down the pipeline.
  typedef struct packed {
    logic valid;
    logic box_ok;
    logic first;
    logic last;
    logic wzero;
  } meta_t;

  // Matrix element r*4+c, Q16.16.
  typedef logic [15:0][31:0] mat_t;

  typedef logic [3:0][ACC_W-1:0] acc_vec_t;

endpackage

`default_nettype wire

@@ src/aabb_matrix_transform.sv @@
// Box transform with perspective divide, signed Q16.16.
// Box channel: box (box_t) moves on box_valid with box_stall low. Each box is
// sent through as eight corners, one per cycle while result_stall does not hold
// the pipeline; the next box is taken in the cycle the last corner issues.
// Corner path: sequencer, 12 32x32 multipliers, row sums, three 18-stage
// dividers (x, y, z over w), then the min/max unit. Result channel: result
// (result_t) moves on result_valid with result_stall low.
// The matrix sits in eight 64-bit registers at byte address 8*i on the APB
// port; reset loads the identity. Write it only while the block is idle.
// Reset clears the pipeline valids and result_valid.
// While a result waits under result_stall the whole corner pipeline holds;
// one box can still be taken into the sequencer.
// Depends on amt_pkg, amt_cfg_regs, amt_corner_seq, amt_xform, amt_qdiv and amt_bound.
`timescale 1ns / 1ps
`default_nettype none

module aabb_matrix_transform
  import amt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire box_t              box,
  input  wire logic              box_valid,
  output logic                   box_stall,
  output result_t                result,
  output logic                   result_valid,
  input  wire logic              result_stall,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [REG_W-1:0]  pwdata,
  output logic      [REG_W-1:0]  prdata,
  output logic                   pready
);

  logic     en;
  mat_t     mat;
  logic signed [31:0] cx, cy, cz, qx, qy, qz;
  meta_t    cmeta, ameta;
  acc_vec_t acc;
  meta_t    dly [DIV_LAT];

  assign pready = 1'b1;
  assign en     = !result_valid || !result_stall;

  amt_cfg_regs u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .mat
  );

  amt_corner_seq u_seq (
    .clk, .rst, .en, .box, .box_valid, .box_stall, .cx, .cy, .cz, .cmeta
  );

  amt_xform u_xf (
    .clk, .rst, .en, .mat, .cx, .cy, .cz, .cmeta, .acc, .ameta
  );

  amt_qdiv u_div_x (.clk, .en, .num(acc[0]), .den(acc[3]), .q(qx));
  amt_qdiv u_div_y (.clk, .en, .num(acc[1]), .den(acc[3]), .q(qy));
  amt_qdiv u_div_z (.clk, .en, .num(acc[2]), .den(acc[3]), .q(qz));

  // Corner sideband follows the dividers; w == 0 is noted on entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_LAT; i++) dly[i] <= '0;
    end else if (en) begin
      dly[0] <= {ameta.valid, ameta.box_ok, ameta.first, ameta.last, acc[3] == '0};
      for (int i = 1; i < DIV_LAT; i++) dly[i] <= dly[i-1];
    end
  end

  amt_bound u_bnd (
    .clk, .rst, .en, .qmeta(dly[DIV_LAT-1]), .qx, .qy, .qz,
    .result, .result_valid, .result_stall
  );

endmodule

`default_nettype wire

@@ src/amt_cfg_regs.sv @@
// Matrix configuration registers behind the APB-style port.
// Depends on amt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module amt_cfg_regs
  import amt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [REG_W-1:0]  pwdata,
  output logic      [REG_W-1:0]  prdata,
  output mat_t                   mat
);

  logic [REG_W-1:0] regs [NREGS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NREGS; i++) regs[i] <= CFG_RESET[i];
    end else if (psel && penable && pwrite) begin
      regs[paddr[ADDR_W-1:3]] <= pwdata;
    end
  end

  assign prdata = regs[paddr[ADDR_W-1:3]];

  for (genvar r = 0; r < 4; r++) begin : g_row
    for (genvar c = 0; c < 4; c++) begin : g_col
      assign mat[r*4+c] = regs[r*2 + c/2][32*(c%2) +: 32];
    end
  end

endmodule

`default_nettype wire

@@ src/amt_corner_seq.sv @@
// Holds the accepted box and issues its eight corners, one per cycle while en is high.
// Depends on amt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module amt_corner_seq
  import amt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire box_t        box,
  input  wire logic        box_valid,
  output logic             box_stall,
  output logic signed [31:0] cx,
  output logic signed [31:0] cy,
  output logic signed [31:0] cz,
  output meta_t            cmeta
);

  logic       busy;
  logic [2:0] cnt;
  box_t       held;
  logic       take;

  assign box_stall = busy && !(en && cnt == 3'd7);
  assign take      = box_valid && !box_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      cnt   <= 3'd0;
      cmeta <= '0;
    end else begin
      if (en) begin
        cmeta.valid  <= busy;
        cmeta.box_ok <= held.box_ok;
        cmeta.first  <= (cnt == 3'd0);
        cmeta.last   <= (cnt == 3'd7);
        cmeta.wzero  <= 1'b0;
      end
      if (take) begin
        busy <= 1'b1;
        cnt  <= 3'd0;
      end else if (en && busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd7) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) held <= box;
    if (en) begin
      cx <= cnt[2] ? held.hi_x : held.lo_x;
      cy <= cnt[1] ? held.hi_y : held.lo_y;
      cz <= cnt[0] ? held.hi_z : held.lo_z;
    end
  end

endmodule

`default_nettype wire

@@ src/amt_xform.sv @@
// Matrix times corner: registered products, then floored row sums.
// Depends on amt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module amt_xform
  import amt_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire mat_t          mat,
  input  wire logic signed [31:0] cx,
  input  wire logic signed [31:0] cy,
  input  wire logic signed [31:0] cz,
  input  wire meta_t         cmeta,
  output acc_vec_t           acc,
  output meta_t              ameta
);

  logic signed [63:0] prod [4][3];
  logic signed [31:0] m3 [4];
  meta_t              pmeta;

  always_ff @(posedge clk) begin
    if (rst) begin
      pmeta <= '0;
      ameta <= '0;
    end else if (en) begin
      pmeta <= cmeta;
      ameta <= pmeta;
    end
  end

  for (genvar r = 0; r < 4; r++) begin : g_row
    logic signed [ACC_W-1:0] sum;

    // Column 3 multiplies w = 1.0, so its floored product is the element itself.
    assign sum = ACC_W'(prod[r][0] >>> 16) + ACC_W'(prod[r][1] >>> 16)
               + ACC_W'(prod[r][2] >>> 16) + ACC_W'(m3[r]);

    always_ff @(posedge clk) begin
      if (en) begin
        prod[r][0] <= $signed(mat[r*4+0]) * cx;
        prod[r][1] <= $signed(mat[r*4+1]) * cy;
        prod[r][2] <= $signed(mat[r*4+2]) * cz;
        m3[r]      <= $signed(mat[r*4+3]);
        acc[r]     <= sum;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/amt_qdiv.sv @@
// Pipelined signed Q16.16 divide, truncating, saturated to 32 bits.
// Two quotient bits per stage. Depends on amt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module amt_qdiv
  import amt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [ACC_W-1:0] num,
  input  wire logic [ACC_W-1:0] den,
  output logic signed [31:0]    q
);

  typedef struct packed {
    logic [ACC_W-1:0] r;
    logic [31:0]      nlo;
    logic [31:0]      qb;
  } dstate_t;

  function automatic dstate_t div_step(dstate_t s, logic [ACC_W-1:0] d);
    logic [ACC_W:0] rr;
    dstate_t        o;
    rr    = {s.r, s.nlo[31]};
    o.nlo = {s.nlo[30:0], 1'b0};
    if (rr >= {1'b0, d}) begin
      o.r  = ACC_W'(rr - {1'b0, d});
      o.qb = {s.qb[30:0], 1'b1};
    end else begin
      o.r  = ACC_W'(rr);
      o.qb = {s.qb[30:0], 1'b0};
    end
    return o;
  endfunction

  dstate_t          st  [DIV_STAGES+1];
  logic [ACC_W-1:0] ud  [DIV_STAGES+1];
  logic             neg [DIV_STAGES+1];
  logic             sat [DIV_STAGES+1];

  logic [ACC_W-1:0] un_c, ud_c;
  assign un_c = num[ACC_W-1] ? ACC_W'(-num) : num;
  assign ud_c = den[ACC_W-1] ? ACC_W'(-den) : den;

  // Quotient of un*2^16/ud needs more than 32 bits exactly when un >= ud*2^16.
  always_ff @(posedge clk) begin
    if (en) begin
      st[0].r   <= ACC_W'(un_c[ACC_W-1:16]);
      st[0].nlo <= {un_c[15:0], 16'd0};
      st[0].qb  <= 32'd0;
      ud[0]     <= ud_c;
      neg[0]    <= num[ACC_W-1] ^ den[ACC_W-1];
      sat[0]    <= {16'd0, un_c} >= {ud_c, 16'd0};
    end
  end

  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_stage
    dstate_t nx;
    assign nx = div_step(div_step(st[k-1], ud[k-1]), ud[k-1]);
    always_ff @(posedge clk) begin
      if (en) begin
        st[k]  <= nx;
        ud[k]  <= ud[k-1];
        neg[k] <= neg[k-1];
        sat[k] <= sat[k-1];
      end
    end
  end

  logic [32:0] mag, mag_n;
  logic [31:0] q_next;
  assign mag   = sat[DIV_STAGES] ? 33'h1_0000_0000 : {1'b0, st[DIV_STAGES].qb};
  assign mag_n = (mag > 33'h0_8000_0000) ? 33'h0_8000_0000 : mag;

  always_comb begin
    if (!neg[DIV_STAGES]) q_next = (mag > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    else                  q_next = 32'(-mag_n);
  end

  always_ff @(posedge clk) begin
    if (en) q <= q_next;
  end

endmodule

`default_nettype wire

@@ src/amt_bound.sv @@
// Running min/max over a box's eight corners and the result register.
// Depends on amt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module amt_bound
  import amt_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire meta_t         qmeta,
  input  wire logic signed [31:0] qx,
  input  wire logic signed [31:0] qy,
  input  wire logic signed [31:0] qz,
  output result_t            result,
  output logic               result_valid,
  input  wire logic          result_stall
);

  logic signed [31:0] mn [3], mx [3], mn_n [3], mx_n [3], qv [3];
  logic               fault, fault_n, ok;

  assign qv[0] = qx;
  assign qv[1] = qy;
  assign qv[2] = qz;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mn_n[i] = (qmeta.first || qv[i] < mn[i]) ? qv[i] : mn[i];
      mx_n[i] = (qmeta.first || qv[i] > mx[i]) ? qv[i] : mx[i];
    end
    fault_n = qmeta.wzero || (!qmeta.first && fault);
    ok      = qmeta.box_ok && !fault_n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      if (en && qmeta.valid && qmeta.last) result_valid <= 1'b1;
      else if (result_valid && !result_stall) result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && qmeta.valid) begin
      mn    <= mn_n;
      mx    <= mx_n;
      fault <= fault_n;
      if (qmeta.last) begin
        result.new_lo_x     <= ok ? mn_n[0] : 32'sd0;
        result.new_lo_y     <= ok ? mn_n[1] : 32'sd0;
        result.new_lo_z     <= ok ? mn_n[2] : 32'sd0;
        result.new_hi_x     <= ok ? mx_n[0] : 32'sd0;
        result.new_hi_y     <= ok ? mx_n[1] : 32'sd0;
        result.new_hi_z     <= ok ? mx_n[2] : 32'sd0;
        result.result_ok    <= ok;
        result.divide_fault <= qmeta.box_ok && fault_n;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/amt_checker.sv @@
// Port-level checks for aabb_matrix_transform, attached by bind.
// Depends on amt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module amt_checker
  import amt_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    box_valid,
  input wire logic    box_stall,
  input wire result_t result,
  input wire logic    result_valid,
  input wire logic    result_stall
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    box_valid && !box_stall |=> box_stall)
    else $error("box taken while corners still issuing");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.result_ok && result.divide_fault))
    else $error("ok and fault both set");

  a_zero_bad: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.result_ok |->
      result.new_lo_x == 0 && result.new_lo_y == 0 && result.new_lo_z == 0 &&
      result.new_hi_x == 0 && result.new_hi_y == 0 && result.new_hi_z == 0)
    else $error("invalid result with nonzero box");

  a_order: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.result_ok |->
      result.new_lo_x <= result.new_hi_x && result.new_lo_y <= result.new_hi_y &&
      result.new_lo_z <= result.new_hi_z)
    else $error("result min above max");

endmodule

bind aabb_matrix_transform amt_checker u_chk (.*);

`default_nettype wire

@@ test/tb.sv @@
// Testbench for aabb_matrix_transform: directed and random boxes under several matrices.
// Predicts each result in Q16.16 and checks the results in order; needs amt_pkg and the RTL.
`timescale 1ns / 1ps
`default_nettype none

module tb;
  import amt_pkg::*;

  logic clk = 0;
  logic rst = 1;
  box_t box = '0;
  logic box_valid = 0;
  logic box_stall;
  result_t result;
  logic result_valid;
  logic result_stall = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [REG_W-1:0] pwdata = '0;
  logic [REG_W-1:0] prdata;
  logic pready;

  aabb_matrix_transform dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  logic [63:0] mat_regs [NREGS];
  box_t pending_boxes [$];
  result_t expected_boxes [$];
  int errors = 0;
  int cycles = 0;
  int burst_left = 0, gap_left = 0;
  int stall_mode = 0;
  int boxes_sent = 0, results_seen = 0, faults_seen = 0;

  function automatic logic signed [63:0] elem(int r, int c);
    logic [63:0] w;
    w = mat_regs[r*2 + c/2];
    return (c % 2) ? 64'(signed'(w[63:32])) : 64'(signed'(w[31:0]));
  endfunction

  // Q16.16 quotient, truncated toward zero then saturated
  function automatic logic signed [31:0] q_div(logic signed [63:0] n, logic signed [63:0] d);
    logic signed [127:0] q;
    q = (128'(n) <<< 16) / 128'(d);
    if (q > 128'sh7FFFFFFF) return 32'h7FFFFFFF;
    if (q < -128'sh80000000) return 32'h80000000;
    return q[31:0];
  endfunction

  function automatic result_t transform_box(box_t b);
    result_t res;
    logic signed [63:0] v [4];
    logic signed [63:0] acc [4];
    logic signed [31:0] q [3];
    logic signed [31:0] mn [3];
    logic signed [31:0] mx [3];
    res = '0;
    if (!b.box_ok) return res;
    for (int k = 0; k < 8; k++) begin
      v[0] = (k & 4) ? 64'(b.hi_x) : 64'(b.lo_x);
      v[1] = (k & 2) ? 64'(b.hi_y) : 64'(b.lo_y);
      v[2] = (k & 1) ? 64'(b.hi_z) : 64'(b.lo_z);
      v[3] = 64'sd65536;
      for (int r = 0; r < 4; r++) begin
        acc[r] = 0;
        for (int c = 0; c < 4; c++) acc[r] += (elem(r, c) * v[c]) >>> 16;
      end
      if (acc[3] == 0) begin
        res.divide_fault = 1;
        return res;
      end
      for (int r = 0; r < 3; r++) begin
        q[r] = q_div(acc[r], acc[3]);
        if (k == 0 || q[r] < mn[r]) mn[r] = q[r];
        if (k == 0 || q[r] > mx[r]) mx[r] = q[r];
      end
    end
    res.new_lo_x = mn[0]; res.new_lo_y = mn[1]; res.new_lo_z = mn[2];
    res.new_hi_x = mx[0]; res.new_hi_y = mx[1]; res.new_hi_z = mx[2];
    res.result_ok = 1;
    return res;
  endfunction

  // driver: bursts and gaps; payload held while stalled
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (box_valid && !box_stall) begin
        expected_boxes.push_back(transform_box(box));
        boxes_sent <= boxes_sent + 1;
      end
      if (!box_valid || !box_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          box_valid <= 0;
        end else if (pending_boxes.size() > 0) begin
          box <= pending_boxes.pop_front();
          box_valid <= 1;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 30);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          box_valid <= 0;
        end
      end
      if (cycles % 200 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: result_stall <= 0;
        1: result_stall <= ($urandom_range(0, 3) == 0);
        2: result_stall <= ($urandom_range(0, 1) == 0);
        default: result_stall <= (cycles % 16) < 9;
      endcase
    end
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // monitor
  always @(posedge clk) begin
    result_t e;
    if (!rst && result_valid && !result_stall) begin
      if (expected_boxes.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        e = expected_boxes.pop_front();
        results_seen++;
        if (e.divide_fault) faults_seen++;
        check_field("new_lo_x", e.new_lo_x, result.new_lo_x);
        check_field("new_lo_y", e.new_lo_y, result.new_lo_y);
        check_field("new_lo_z", e.new_lo_z, result.new_lo_z);
        check_field("new_hi_x", e.new_hi_x, result.new_hi_x);
        check_field("new_hi_y", e.new_hi_y, result.new_hi_y);
        check_field("new_hi_z", e.new_hi_z, result.new_hi_z);
        check_field("result_ok", 32'(e.result_ok), 32'(result.result_ok));
        check_field("divide_fault", 32'(e.divide_fault), 32'(result.divide_fault));
      end
    end
  end

  // cycle limit, far above what the full run needs even under the longest stalls
  always @(posedge clk) begin
    if (cycles >= 500000) begin
      $display("tb: errors");
      $finish;
    end
  end

  task automatic write_reg(int idx, logic [63:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= ADDR_W'(idx * 8); pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    mat_regs[idx] = val;
  endtask

  task automatic drain();
    while (pending_boxes.size() > 0 || box_valid || expected_boxes.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h7FFFFFFF;
      2: return 32'h80000000;
      default: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
    endcase
  endfunction

  function automatic logic [31:0] rand_elem();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'($urandom_range(0, 4)) << 16;
      2: return -(32'($urandom_range(1, 3)) << 16);
      default: return 32'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
    endcase
  endfunction

  function automatic box_t rand_box();
    box_t b;
    b.lo_x = rand_coord(); b.lo_y = rand_coord(); b.lo_z = rand_coord();
    b.hi_x = rand_coord(); b.hi_y = rand_coord(); b.hi_z = rand_coord();
    b.box_ok = ($urandom_range(0, 9) != 0);
    return b;
  endfunction

  initial begin
    box_t b;
    logic [63:0] m [NREGS];
    for (int i = 0; i < NREGS; i++) mat_regs[i] = CFG_RESET[i];
    repeat (4) @(posedge clk);
    rst <= 0;

    // identity: extremes, invalid box, reversed box
    b = '{32'h80000000, 32'h80000000, 32'h80000000,
          32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1};
    pending_boxes.push_back(b);
    b = '{32'h7FFFFFFF, 32'h00010000, 32'hFFFF0000, 32'h80000000, 32'h0, 32'h1, 1'b1};
    pending_boxes.push_back(b);
    b = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
          32'hFFFFFFFF, 1'b0};
    pending_boxes.push_back(b);
    b = '0;
    pending_boxes.push_back(b);
    b.box_ok = 1;
    pending_boxes.push_back(b);
    drain();

    // w row zero gives divide fault
    write_reg(7, 64'h0);
    pending_boxes.push_back(b);
    b = '{32'h10000, 32'h20000, 32'h30000, 32'h40000, 32'h50000, 32'h60000, 1'b1};
    pending_boxes.push_back(b);
    drain();

    // w = x: negative w on some corners only; then small w, saturation
    write_reg(6, 64'h0000_0000_0001_0000);
    pending_boxes.push_back('{32'hFFFF0000, 32'h0, 32'h0, 32'h10000, 32'h0, 32'h0, 1'b1});
    pending_boxes.push_back('{32'h1, 32'h7FFFFFFF, 32'h80000000, 32'h2, 32'h1, 32'h5, 1'b1});
    drain();

    // all-ones and extreme matrices
    for (int i = 0; i < NREGS; i++) write_reg(i, 64'hFFFF_FFFF_FFFF_FFFF);
    pending_boxes.push_back('{32'h80000000, 32'h1, 32'h7FFFFFFF, 32'h0, 32'h80000000,
                              32'h12345, 1'b1});
    for (int i = 0; i < 6; i++) pending_boxes.push_back(rand_box());
    drain();
    for (int i = 0; i < NREGS; i++)
      write_reg(i, (i % 2) ? 64'h7FFF_FFFF_8000_0000 : 64'h8000_0000_7FFF_FFFF);
    for (int i = 0; i < 6; i++) pending_boxes.push_back(rand_box());
    drain();

    // random phases with random matrices
    for (int ph = 0; ph < 10; ph++) begin
      for (int i = 0; i < NREGS; i++) m[i] = {rand_elem(), rand_elem()};
      if (ph % 3 == 0) m[7] = {32'h10000, rand_elem()};
      for (int i = 0; i < NREGS; i++) write_reg(i, m[i]);
      for (int i = 0; i < 130; i++) pending_boxes.push_back(rand_box());
      drain();
    end

    $display("tb: %0d boxes sent, %0d results checked, %0d divide faults",
             boxes_sent, results_seen, faults_seen);
    $display("tb: matrices covered identity, zero w row, extremes and 10 random sets");
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule

`default_nettype wire

@@ aabb_matrix_transform.f @@
src/amt_pkg.sv
src/amt_cfg_regs.sv
src/amt_corner_seq.sv
src/amt_xform.sv
src/amt_qdiv.sv
src/amt_bound.sv
src/aabb_matrix_transform.sv
src/amt_checker.sv
test/tb.sv
